/* rtl/atss_pkg.sv */
// atss_pkg: item types, register codes and sequencer states of the
// approximate-time sensor sync unit; no dependencies
package atss_pkg;

	localparam int STAMP_W = 48;
	localparam int TAG_W   = 16;
	localparam int ENTRY_W = STAMP_W + TAG_W;
	localparam int MAX_RESULTS = 32;
	localparam int RES_CNT_W   = 6;

	typedef struct packed {
		logic [2:0]         sensor_index;
		logic [STAMP_W-1:0] stamp;
		logic [TAG_W-1:0]   message_tag;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         out_sensor;
		logic [STAMP_W-1:0] out_stamp;
		logic [TAG_W-1:0]   out_tag;
		logic               last_of_set;
	} out_item_t;

	typedef logic [1:0] cfg_index_t;
	localparam cfg_index_t CFG_MAX_INTERVAL   = 2'd0;
	localparam cfg_index_t CFG_QUEUE_LIMIT    = 2'd1;
	localparam cfg_index_t CFG_SENSORS_IN_USE = 2'd2;

	localparam logic [31:0] MAX_INTERVAL_RST = 32'd100000;
	localparam logic [3:0]  QUEUE_LIMIT_RST  = 4'd8;
	localparam logic [2:0]  SENSORS_RST      = 3'd4;

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b00000000001,
		ST_CHECK  = 11'b00000000010,
		ST_RD     = 11'b00000000100,
		ST_CMP    = 11'b00000001000,
		ST_EVAL   = 11'b00000010000,
		ST_MOVE   = 11'b00000100000,
		ST_DECIDE = 11'b00001000000,
		ST_VEVAL  = 11'b00010000000,
		ST_OUT    = 11'b00100000000,
		ST_UPD    = 11'b01000000000,
		ST_OVF    = 11'b10000000000
	} state_t;

endpackage

/* rtl/atss_ram.sv */
// atss_ram: generic single-write, single-read RAM with registered read
// no dependencies
module atss_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 36
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* rtl/approximate_time_sensor_sync_unit.sv */
// approximate_time_sensor_sync_unit: per-sensor message queues and the
// approximate-time set search; depends on atss_pkg and atss_ram
//
// channel   direction  handshake                  payload
// request   in         start & !busy              in_item_t
// result    out        result_valid, one cycle    out_item_t
// cfg       in         cfg_valid & cfg_ready      cfg_index, cfg_data
//
// an item that does not start a search goes through the check and overflow
// states back to idle; otherwise each pass over the queue fronts reads every
// active sensor in turn through the single read port of the message RAM, then
// decides; a published set shows one member per sensor, then queues update.
// async active-low reset clears queues, pivot and registers to defaults.
// results cannot be held off: each shows for exactly one cycle.
module approximate_time_sensor_sync_unit
	import atss_pkg::*;
#(
	parameter int NUM_SENSORS = 4,
	parameter int QUEUE_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_item_t    request,
	output logic        result_valid,
	output out_item_t   result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  cfg_index_t  cfg_index,
	input  logic [31:0] cfg_data
);
	localparam int RING  = QUEUE_DEPTH + 1;
	localparam int HW    = $clog2(RING);
	localparam int QW    = $clog2(RING + 1);
	localparam int SW    = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
	localparam int CW    = $clog2(NUM_SENSORS + 1);
	localparam int DEPTH = NUM_SENSORS * RING;
	localparam int AW    = $clog2(DEPTH);

	state_t state_q;

	logic [31:0] max_interval_q;
	logic [3:0]  queue_limit_q;
	logic [2:0]  sensors_q;

	logic [QW-1:0] pend_q   [NUM_SENSORS];
	logic [QW-1:0] passed_q [NUM_SENSORS];
	logic [HW-1:0] head_q   [NUM_SENSORS];
	logic [QW-1:0] moves_q  [NUM_SENSORS];
	logic [NUM_SENSORS-1:0] dropped_q;
	logic [ENTRY_W-1:0] front_q [NUM_SENSORS];
	logic [ENTRY_W-1:0] cand_q  [NUM_SENSORS];

	logic               pivot_valid_q;
	logic [SW-1:0]      pivot_sensor_q;
	logic [STAMP_W-1:0] pivot_stamp_q;
	logic [STAMP_W-1:0] cand_start_q;
	logic [STAMP_W-1:0] cand_end_q;

	logic [STAMP_W-1:0] st_q, et_q;
	logic [SW-1:0]      si_q, ei_q;
	logic [SW-1:0]      sc_i_q;
	logic               virt_q;
	logic               phase_q;
	logic [SW-1:0]      idx_q;
	logic [RES_CNT_W-1:0] res_n_q;

	logic [CW-1:0] s;
	logic [QW-1:0] lim;
	logic          all_nonempty;
	logic          in_ok;
	logic [3:0]    idx4;
	logic [SW-1:0] in_idx;
	logic [QW:0]   in_total;
	logic          do_write;
	logic [AW-1:0] waddr, raddr;
	logic [ENTRY_W-1:0] rdata;
	logic [STAMP_W-1:0] rstamp, t_cmp;
	logic [SW-1:0] last_i;
	logic          pub_now, pub_room;
	logic          undo_now;
	logic signed [STAMP_W:0] d_end, d_start, d_pivot;

	function automatic logic [HW-1:0] slot(input logic [HW-1:0] h, input logic [QW-1:0] k);
		logic [QW:0] sm;
		sm = (QW+1)'(h) + (QW+1)'(k);
		if (sm >= (QW+1)'(RING)) begin
			sm = sm - (QW+1)'(RING);
		end
		return sm[HW-1:0];
	endfunction

	function automatic logic signed [STAMP_W:0] sd(input logic [STAMP_W-1:0] a,
		input logic [STAMP_W-1:0] b);
		return $signed({1'b0, a}) - $signed({1'b0, b});
	endfunction

	function automatic logic [AW-1:0] flat(input logic [SW-1:0] i, input logic [HW-1:0] sl);
		return AW'(int'(i) * RING + int'(sl));
	endfunction

	// clamped register values
	always_comb begin
		if (sensors_q == 3'd0) begin
			s = CW'(1);
		end else if (int'(sensors_q) > NUM_SENSORS) begin
			s = CW'(NUM_SENSORS);
		end else begin
			s = CW'(sensors_q);
		end
		if (queue_limit_q == 4'd0) begin
			lim = QW'(1);
		end else if (int'(queue_limit_q) > QUEUE_DEPTH) begin
			lim = QW'(QUEUE_DEPTH);
		end else begin
			lim = QW'(queue_limit_q);
		end
		all_nonempty = 1'b1;
		for (int i = 0; i < NUM_SENSORS; i++) begin
			if (i < int'(s) && pend_q[i] == '0) begin
				all_nonempty = 1'b0;
			end
		end
	end

	assign busy      = (state_q != ST_IDLE);
	// a write never competes with an accepted item
	assign cfg_ready = (state_q == ST_IDLE) && !start;
	assign last_i    = SW'(s - CW'(1));

	// accept path
	always_comb begin
		idx4     = 4'(request.sensor_index);
		in_idx   = SW'(request.sensor_index);
		in_ok    = idx4 < 4'(s);
		in_total = (QW+1)'(passed_q[in_idx]) + (QW+1)'(pend_q[in_idx]);
		do_write = start && !busy && in_ok && (in_total < (QW+1)'(RING));
		waddr    = flat(in_idx, slot(head_q[in_idx], QW'(in_total)));
	end

	// read address for the scanned sensor
	always_comb begin
		logic [QW-1:0] k;
		k = passed_q[sc_i_q];
		if (virt_q && pend_q[sc_i_q] == '0 && k != '0) begin
			k = k - QW'(1);
		end
		raddr = flat(sc_i_q, slot(head_q[sc_i_q], k));
	end

	atss_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_store (
		.clk  (clk),
		.we   (do_write),
		.waddr(waddr),
		.wdata({request.stamp, request.message_tag}),
		.raddr(raddr),
		.rdata(rdata)
	);

	// value seen by the compare unit for the scanned sensor
	always_comb begin
		rstamp = rdata[ENTRY_W-1:TAG_W];
		t_cmp  = rstamp;
		if (virt_q && pend_q[sc_i_q] == '0) begin
			if (passed_q[sc_i_q] != '0 && rstamp > pivot_stamp_q) begin
				t_cmp = rstamp;
			end else begin
				t_cmp = pivot_stamp_q;
			end
		end
	end

	always_comb begin
		d_end    = sd(et_q, cand_end_q);
		d_start  = sd(st_q, cand_start_q);
		d_pivot  = sd(pivot_stamp_q, cand_start_q);
		pub_now  = (state_q == ST_DECIDE) ? (si_q == pivot_sensor_q || d_end >= d_pivot)
		                                  : (d_end >= d_pivot);
		pub_room = (7'(res_n_q) + 7'(s)) <= 7'(MAX_RESULTS);
		undo_now = (d_end < d_start) || (si_q == pivot_sensor_q) ||
		           (st_q > pivot_stamp_q) || (pend_q[si_q] == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			max_interval_q <= MAX_INTERVAL_RST;
			queue_limit_q  <= QUEUE_LIMIT_RST;
			sensors_q      <= SENSORS_RST;
			for (int i = 0; i < NUM_SENSORS; i++) begin
				pend_q[i]   <= '0;
				passed_q[i] <= '0;
				head_q[i]   <= '0;
				moves_q[i]  <= '0;
				front_q[i]  <= '0;
				cand_q[i]   <= '0;
			end
			dropped_q      <= '0;
			pivot_valid_q  <= 1'b0;
			pivot_sensor_q <= '0;
			pivot_stamp_q  <= '0;
			cand_start_q   <= '0;
			cand_end_q     <= '0;
			st_q           <= '0;
			et_q           <= '0;
			si_q           <= '0;
			ei_q           <= '0;
			sc_i_q         <= '0;
			virt_q         <= 1'b0;
			phase_q        <= 1'b0;
			idx_q          <= '0;
			res_n_q        <= '0;
			result_valid   <= 1'b0;
			result         <= '0;
		end else begin
			result_valid <= (state_q == ST_OUT);
			case (state_q)
				ST_IDLE: begin
					if (cfg_valid && cfg_ready) begin
						case (cfg_index)
							CFG_MAX_INTERVAL: max_interval_q <= cfg_data;
							CFG_QUEUE_LIMIT:  queue_limit_q  <= cfg_data[3:0];
							CFG_SENSORS_IN_USE: begin
								sensors_q <= cfg_data[2:0];
								for (int i = 0; i < NUM_SENSORS; i++) begin
									pend_q[i]   <= '0;
									passed_q[i] <= '0;
									head_q[i]   <= '0;
								end
								dropped_q      <= '0;
								pivot_valid_q  <= 1'b0;
								pivot_sensor_q <= '0;
								pivot_stamp_q  <= '0;
								cand_start_q   <= '0;
								cand_end_q     <= '0;
							end
							default: ;
						endcase
					end else if (do_write) begin
						pend_q[in_idx] <= pend_q[in_idx] + QW'(1);
						idx_q   <= in_idx;
						phase_q <= 1'b0;
						res_n_q <= '0;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (all_nonempty) begin
						sc_i_q  <= '0;
						virt_q  <= 1'b0;
						state_q <= ST_RD;
					end else if (!phase_q) begin
						state_q <= ST_OVF;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_RD: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (!virt_q) begin
						front_q[sc_i_q] <= rdata;
					end
					if (sc_i_q == '0) begin
						st_q <= t_cmp;
						et_q <= t_cmp;
						si_q <= '0;
						ei_q <= '0;
					end else begin
						if (t_cmp < st_q) begin
							st_q <= t_cmp;
							si_q <= sc_i_q;
						end
						if (t_cmp >= et_q) begin
							et_q <= t_cmp;
							ei_q <= sc_i_q;
						end
					end
					if (sc_i_q == last_i) begin
						state_q <= virt_q ? ST_VEVAL : ST_EVAL;
					end else begin
						sc_i_q  <= sc_i_q + SW'(1);
						state_q <= ST_RD;
					end
				end
				ST_EVAL: begin
					for (int i = 0; i < NUM_SENSORS; i++) begin
						if (i < int'(s) && SW'(i) != ei_q) begin
							dropped_q[i] <= 1'b0;
						end
					end
					if (!pivot_valid_q &&
					    ((et_q - st_q) > STAMP_W'(max_interval_q) || dropped_q[ei_q])) begin
						// delete front of the earliest queue
						passed_q[si_q] <= '0;
						if (pend_q[si_q] != '0) begin
							head_q[si_q] <= slot(head_q[si_q], passed_q[si_q] + QW'(1));
							pend_q[si_q] <= pend_q[si_q] - QW'(1);
						end else begin
							head_q[si_q] <= slot(head_q[si_q], passed_q[si_q]);
						end
						state_q <= ST_CHECK;
					end else begin
						if (!pivot_valid_q || d_end < d_start) begin
							for (int i = 0; i < NUM_SENSORS; i++) begin
								if (i < int'(s)) begin
									cand_q[i]   <= front_q[i];
									head_q[i]   <= slot(head_q[i], passed_q[i]);
									passed_q[i] <= '0;
								end
							end
							cand_start_q <= st_q;
							cand_end_q   <= et_q;
						end
						if (!pivot_valid_q) begin
							pivot_valid_q  <= 1'b1;
							pivot_sensor_q <= ei_q;
							pivot_stamp_q  <= et_q;
						end
						state_q <= ST_MOVE;
					end
				end
				ST_MOVE: begin
					if (pend_q[si_q] != '0) begin
						pend_q[si_q]   <= pend_q[si_q] - QW'(1);
						passed_q[si_q] <= passed_q[si_q] + QW'(1);
					end
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (pub_now) begin
						sc_i_q  <= '0;
						state_q <= pub_room ? ST_OUT : ST_UPD;
					end else if (!all_nonempty) begin
						for (int i = 0; i < NUM_SENSORS; i++) begin
							moves_q[i] <= '0;
						end
						sc_i_q  <= '0;
						virt_q  <= 1'b1;
						state_q <= ST_RD;
					end else begin
						state_q <= ST_CHECK;
					end
				end
				ST_VEVAL: begin
					if (pub_now) begin
						sc_i_q  <= '0;
						state_q <= pub_room ? ST_OUT : ST_UPD;
					end else if (undo_now) begin
						for (int i = 0; i < NUM_SENSORS; i++) begin
							if (i < int'(s)) begin
								passed_q[i] <= passed_q[i] - moves_q[i];
								pend_q[i]   <= pend_q[i] + moves_q[i];
							end
						end
						state_q <= ST_CHECK;
					end else begin
						pend_q[si_q]   <= pend_q[si_q] - QW'(1);
						passed_q[si_q] <= passed_q[si_q] + QW'(1);
						moves_q[si_q]  <= moves_q[si_q] + QW'(1);
						sc_i_q  <= '0;
						state_q <= ST_RD;
					end
				end
				ST_OUT: begin
					result.out_sensor  <= 2'(sc_i_q);
					result.out_stamp   <= cand_q[sc_i_q][ENTRY_W-1:TAG_W];
					result.out_tag     <= cand_q[sc_i_q][TAG_W-1:0];
					result.last_of_set <= (sc_i_q == last_i);
					res_n_q <= res_n_q + RES_CNT_W'(1);
					if (sc_i_q == last_i) begin
						state_q <= ST_UPD;
					end else begin
						sc_i_q <= sc_i_q + SW'(1);
					end
				end
				ST_UPD: begin
					pivot_valid_q <= 1'b0;
					for (int i = 0; i < NUM_SENSORS; i++) begin
						if (i < int'(s)) begin
							passed_q[i] <= '0;
							if ((pend_q[i] + passed_q[i]) != '0) begin
								head_q[i] <= slot(head_q[i], QW'(1));
								pend_q[i] <= pend_q[i] + passed_q[i] - QW'(1);
							end else begin
								pend_q[i] <= '0;
							end
						end
					end
					state_q <= ST_CHECK;
				end
				ST_OVF: begin
					if ((QW+1)'(passed_q[idx_q]) + (QW+1)'(pend_q[idx_q]) > (QW+1)'(lim)) begin
						for (int i = 0; i < NUM_SENSORS; i++) begin
							if (i < int'(s)) begin
								passed_q[i] <= '0;
								// oldest message of the overflowing queue goes away
								if (SW'(i) == idx_q && (pend_q[i] + passed_q[i]) != '0) begin
									head_q[i] <= slot(head_q[i], QW'(1));
									pend_q[i] <= pend_q[i] + passed_q[i] - QW'(1);
								end else begin
									pend_q[i] <= pend_q[i] + passed_q[i];
								end
							end
						end
						dropped_q[idx_q] <= 1'b1;
						if (pivot_valid_q) begin
							pivot_valid_q <= 1'b0;
							phase_q       <= 1'b1;
							state_q       <= ST_CHECK;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

/* rtl/atss_checker.sv */
// atss_checker: port-level assertions on result bursts of the sync unit
// depends on atss_pkg; bound to approximate_time_sensor_sync_unit
module atss_checker
	import atss_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      busy,
	input logic      result_valid,
	input out_item_t result
);
	// results only come out while an item is in work
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy) else $error("result outside busy");

	// members of a set come in consecutive cycles
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last_of_set |=> result_valid)
		else $error("gap inside set");

	a_sensor_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last_of_set |=>
		result.out_sensor == 2'($past(result.out_sensor) + 2'd1))
		else $error("set members out of order");

	// queue update cycle follows every set
	a_gap_after: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last_of_set |=> !result_valid)
		else $error("no gap after set");
endmodule

bind approximate_time_sensor_sync_unit atss_checker u_atss_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.busy        (busy),
	.result_valid(result_valid),
	.result      (result)
);

/* tb/approximate_time_sensor_sync_unit_tb.sv */
// testbench of approximate_time_sensor_sync_unit: drives message items and
// register writes, predicts each matched set with a behavioral copy of the queues
// and checks results in order; depends on atss_pkg and the rtl of the unit
`timescale 1ns / 100ps

module approximate_time_sensor_sync_unit_tb;
	import atss_pkg::*;

	localparam int NS = 4;
	localparam int QD = 8;
	localparam int SLOTS = QD + 1;
	localparam int WATCHDOG = 20000;
	localparam int EXP_DEPTH = 4096;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	in_item_t request = '0;
	logic result_valid;
	out_item_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_index_t cfg_index = CFG_MAX_INTERVAL;
	logic [31:0] cfg_data = '0;

	approximate_time_sensor_sync_unit uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .request(request),
		.result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// predictor state
	logic [63:0] msg_ring [NS][SLOTS];
	int unsigned n_pend [NS];
	int unsigned n_past [NS];
	int unsigned head [NS];
	bit dropped [NS];
	bit piv_ok;
	int unsigned piv_sensor;
	logic [47:0] piv_stamp, set_start, set_end;
	logic [63:0] set_entry [NS];
	logic [31:0] r_interval;
	logic [3:0] r_limit;
	logic [2:0] r_sensors;
	int n_set_results;

	// expected results, written by the predictor and read by the checker
	out_item_t exp_mem [EXP_DEPTH];
	int exp_wr = 0;
	int exp_rd = 0;
	int errors = 0;
	int idle_cycles = 0;
	int send_idle_pct = 37;

	function automatic int unsigned active_cnt();
		int unsigned s;
		s = r_sensors;
		if (s < 1) s = 1;
		if (s > NS) s = NS;
		return s;
	endfunction

	function automatic int unsigned slot(int unsigned i, int unsigned k);
		return (head[i] + k) % SLOTS;
	endfunction

	function automatic logic [47:0] front_stamp(int unsigned i);
		return msg_ring[i][slot(i, n_past[i])][63:16];
	endfunction

	function automatic longint sd(logic [47:0] a, logic [47:0] b);
		return longint'({16'd0, a}) - longint'({16'd0, b});
	endfunction

	function automatic int unsigned filled();
		int unsigned c;
		c = 0;
		for (int i = 0; i < active_cnt(); i++)
			if (n_pend[i] > 0) c++;
		return c;
	endfunction

	function automatic void forget_past(int unsigned i);
		head[i] = slot(i, n_past[i]);
		n_past[i] = 0;
	endfunction

	function automatic void to_past(int unsigned i);
		if (n_pend[i] > 0) begin
			n_pend[i]--;
			n_past[i]++;
		end
	endfunction

	function automatic void take_oldest(int unsigned i);
		if (n_pend[i] > 0) begin
			head[i] = slot(i, 1);
			n_pend[i]--;
		end
	endfunction

	function automatic void take_candidate(int unsigned s, logic [47:0] st, logic [47:0] et);
		for (int i = 0; i < s; i++) begin
			set_entry[i] = msg_ring[i][slot(i, n_past[i])];
			forget_past(i);
		end
		set_start = st;
		set_end = et;
	endfunction

	function automatic void emit_set(int unsigned s);
		out_item_t o;
		if (n_set_results + s <= MAX_RESULTS) begin
			for (int i = 0; i < s; i++) begin
				o.out_sensor = i[1:0];
				o.out_stamp = set_entry[i][63:16];
				o.out_tag = set_entry[i][15:0];
				o.last_of_set = (i + 1 == s);
				exp_mem[exp_wr % EXP_DEPTH] = o;
				exp_wr++;
				n_set_results++;
			end
		end
		piv_ok = 0;
		for (int i = 0; i < s; i++) begin
			n_pend[i] += n_past[i];
			n_past[i] = 0;
			take_oldest(i);
		end
	endfunction

	function automatic logic [47:0] lookahead_time(int unsigned i);
		logic [47:0] last;
		if (n_pend[i] > 0) return front_stamp(i);
		if (n_past[i] > 0) begin
			last = msg_ring[i][slot(i, n_past[i] - 1)][63:16];
			return last > piv_stamp ? last : piv_stamp;
		end
		return piv_stamp;
	endfunction

	function automatic void lookahead(int unsigned s);
		int unsigned moves [NS];
		int unsigned vsi;
		logic [47:0] vs, ve, t;
		for (int i = 0; i < NS; i++) moves[i] = 0;
		forever begin
			vsi = 0;
			vs = lookahead_time(0);
			ve = vs;
			for (int i = 0; i < s; i++) begin
				t = lookahead_time(i);
				if (t < vs) begin
					vs = t;
					vsi = i;
				end
				if (t >= ve) ve = t;
			end
			if (sd(ve, set_end) >= sd(piv_stamp, set_start)) begin
				emit_set(s);
				return;
			end
			if (sd(ve, set_end) < sd(vs, set_start) || vsi == piv_sensor ||
			    vs > piv_stamp || n_pend[vsi] == 0) begin
				for (int i = 0; i < s; i++) begin
					n_past[i] -= moves[i];
					n_pend[i] += moves[i];
				end
				return;
			end
			to_past(vsi);
			moves[vsi]++;
		end
	endfunction

	function automatic void search_sets();
		int unsigned s, si, ei;
		logic [47:0] st, et, t;
		s = active_cnt();
		while (filled() == s) begin
			si = 0;
			ei = 0;
			st = front_stamp(0);
			et = st;
			for (int i = 0; i < s; i++) begin
				t = front_stamp(i);
				if (t < st) begin
					st = t;
					si = i;
				end
				if (t >= et) begin
					et = t;
					ei = i;
				end
			end
			for (int i = 0; i < s; i++)
				if (i != ei) dropped[i] = 0;
			if (!piv_ok) begin
				if ({16'd0, et - st} > {32'd0, r_interval} || dropped[ei]) begin
					forget_past(si);
					take_oldest(si);
					continue;
				end
				take_candidate(s, st, et);
				piv_ok = 1;
				piv_sensor = ei;
				piv_stamp = et;
			end else if (sd(et, set_end) < sd(st, set_start)) begin
				take_candidate(s, st, et);
			end
			to_past(si);
			if (si == piv_sensor || sd(et, set_end) >= sd(piv_stamp, set_start))
				emit_set(s);
			else if (filled() < s)
				lookahead(s);
		end
	endfunction

	function automatic void clear_model();
		for (int i = 0; i < NS; i++) begin
			n_pend[i] = 0;
			n_past[i] = 0;
			head[i] = 0;
			dropped[i] = 0;
			set_entry[i] = '0;
		end
		piv_ok = 0;
		piv_sensor = 0;
		piv_stamp = '0;
		set_start = '0;
		set_end = '0;
	endfunction

	function automatic void model_cfg(cfg_index_t idx, logic [31:0] val);
		case (idx)
			CFG_MAX_INTERVAL: r_interval = val;
			CFG_QUEUE_LIMIT: r_limit = val[3:0];
			CFG_SENSORS_IN_USE: begin
				r_sensors = val[2:0];
				clear_model();
			end
			default: ;
		endcase
	endfunction

	function automatic void model_message(in_item_t it);
		int unsigned s, idx, lim, total;
		s = active_cnt();
		idx = it.sensor_index;
		n_set_results = 0;
		if (idx >= s) return;
		total = n_past[idx] + n_pend[idx];
		if (total >= SLOTS) return;
		msg_ring[idx][slot(idx, total)] = {it.stamp, it.message_tag};
		n_pend[idx]++;
		if (filled() == s) search_sets();
		lim = r_limit;
		if (lim < 1) lim = 1;
		if (lim > QD) lim = QD;
		if (n_past[idx] + n_pend[idx] > lim) begin
			for (int i = 0; i < s; i++) begin
				n_pend[i] += n_past[i];
				n_past[i] = 0;
			end
			take_oldest(idx);
			dropped[idx] = 1;
			if (piv_ok) begin
				piv_ok = 0;
				search_sets();
			end
		end
	endfunction

	// result checker and watchdog
	always @(posedge clk) begin
		out_item_t exp_m;
		if (arst_n) begin
			if (result_valid) begin
				if (exp_rd == exp_wr) begin
					$display("%0t: unexpected result %h", $time, result);
					errors++;
				end else begin
					exp_m = exp_mem[exp_rd % EXP_DEPTH];
					exp_rd++;
					if (result.out_sensor !== exp_m.out_sensor ||
					    result.out_stamp !== exp_m.out_stamp ||
					    result.out_tag !== exp_m.out_tag ||
					    result.last_of_set !== exp_m.last_of_set) begin
						$display("%0t: mismatch expected %h actual %h", $time, exp_m, result);
						errors++;
					end
				end
			end
			if (result_valid || (start && !busy) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic write_reg(cfg_index_t idx, logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		model_cfg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait out all expected results plus a tail for work that emits nothing
	task automatic drain();
		while (exp_rd != exp_wr) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic send_message(in_item_t it);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		request <= it;
		do @(posedge clk); while (busy);
		model_message(it);
		@(negedge clk);
		start <= 1'b0;
	endtask

	function automatic in_item_t mk(logic [2:0] si, logic [47:0] st, logic [15:0] tg);
		in_item_t it;
		it.sensor_index = si;
		it.stamp = st;
		it.message_tag = tg;
		return it;
	endfunction

	function automatic in_item_t rand_message(logic [47:0] base);
		in_item_t it;
		it.sensor_index = ($urandom_range(9) == 0) ? 3'($urandom_range(7))
			: 3'($urandom_range(active_cnt() - 1));
		it.stamp = base + 48'($urandom_range(3000));
		if ($urandom_range(19) == 0) it.stamp = {$urandom(), $urandom()};
		it.message_tag = 16'($urandom());
		return it;
	endfunction

	in_item_t directed [$];
	logic [47:0] clock_base;

	initial begin
		r_interval = MAX_INTERVAL_RST;
		r_limit = QUEUE_LIMIT_RST;
		r_sensors = SENSORS_RST;
		clear_model();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, unknown sensors, out of range window
		directed = '{mk(0, 48'd0, 16'h0000), mk(1, 48'd5, 16'hffff),
			mk(2, 48'd10, 16'h1234), mk(3, 48'd12, 16'hffff),
			mk(7, 48'hffff_ffff_ffff, 16'hffff), mk(4, 48'd3, 16'h0001),
			mk(0, 48'd20, 16'haaaa), mk(1, 48'd300000, 16'h5555),
			mk(2, 48'd300001, 16'h0f0f), mk(3, 48'd300002, 16'hf0f0),
			mk(0, 48'd300003, 16'h0102), mk(0, 48'hffff_ffff_fff0, 16'h0a0a),
			mk(1, 48'hffff_ffff_fff1, 16'h0b0b), mk(2, 48'hffff_ffff_fff2, 16'h0c0c),
			mk(3, 48'hffff_ffff_ffff, 16'h0d0d)};
		send_idle_pct = 0;
		foreach (directed[k]) send_message(directed[k]);
		drain();

		// overflow with a small queue limit and a single sensor
		write_reg(CFG_QUEUE_LIMIT, 32'd0);
		write_reg(CFG_SENSORS_IN_USE, 32'd1);
		for (int k = 0; k < 5; k++) send_message(mk(3'(k % 2), 48'(k * 7), 16'(k)));
		drain();
		write_reg(CFG_SENSORS_IN_USE, 32'd0);
		write_reg(CFG_MAX_INTERVAL, 32'd0);
		write_reg(CFG_SENSORS_IN_USE, 32'd7);
		write_reg(CFG_QUEUE_LIMIT, 32'd15);
		for (int k = 0; k < 6; k++) send_message(mk(3'(k % 4), 48'd100, 16'(k)));
		drain();

		// random phases over several settings
		clock_base = 48'd1000;
		for (int ph = 0; ph < 8; ph++) begin
			send_idle_pct = (ph < 3) ? 37 : (ph < 6) ? 81 : 0;
			write_reg(CFG_MAX_INTERVAL, (ph == 7) ? 32'hffff_ffff : 32'($urandom_range(4000)));
			write_reg(CFG_QUEUE_LIMIT, 32'($urandom_range(1, 8)));
			write_reg(CFG_SENSORS_IN_USE, (ph % 4 == 0) ? 32'd4 : 32'($urandom_range(1, 4)));
			for (int k = 0; k < 50; k++) begin
				send_message(rand_message(clock_base));
				clock_base += 48'($urandom_range(600));
				// pause until all expected sets are out
				if (k == 25) while (exp_rd != exp_wr) @(posedge clk);
			end
			drain();
		end

		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
